// ===== src/gww_pkg.sv =====
package gww_pkg;

   // Text bytes with special meaning
   localparam logic [7:0] NL_BYTE = 8'd10;
   localparam logic [7:0] SP_BYTE = 8'd32;

   // Line width register
   localparam int LINE_W = 8;
   localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 8'd75;

   // Pending word store
   localparam int WORD_CAPACITY = 62;
   localparam int WORD_AW = $clog2(WORD_CAPACITY);
   localparam int WLEN_W = $clog2(WORD_CAPACITY + 1);

   // Source of one emitted byte
   typedef enum logic [1:0] {
      SRC_NL,
      SRC_SP,
      SRC_RAM
   } src_type;

   // Controller to datapath commands
   typedef struct packed {
      logic    store;       // append input byte to the pending word
      logic    place;       // run fit check and update line length
      logic    is_space;    // fit check length includes the space
      logic    line_clear;  // restart the line
      logic    word_clear;  // drop the pending word and its overflow flag
      logic    idx_clear;   // restart the word read index
      logic    idx_adv;     // step the word read index
      logic    rd_en;       // read the word store at the read index
      logic    put;         // load the output register
      src_type put_sel;
      logic    put_last;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic wl_zero;      // no pending word
      logic brk_needed;   // fit check fails on a non-empty line
      logic idx_last;     // read index is on the final word byte
      logic out_free;     // output register can take a byte this cycle
   } status_type;

endpackage

// ===== src/gww_ram.sv =====
module gww_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gww_ctrl.sv =====
module gww_ctrl
   import gww_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BRK,
      ST_READ,
      ST_PUT,
      ST_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      tail_ff, tail_in;        // a space or newline follows the word
   logic      tail_nl_ff, tail_nl_in;  // that trailing byte is a newline

   logic is_space;
   logic is_nl;
   logic accept;

   assign is_space = (req_tdata == SP_BYTE);
   assign is_nl    = (req_tdata == NL_BYTE);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept   = req_tvalid && req_tready;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      tail_in    = tail_ff;
      tail_nl_in = tail_nl_ff;
      cmd        = '0;
      cmd.put_sel = SRC_NL;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_tuser) begin
                  // Flush: emit the word unchecked, restart the line
                  cmd.line_clear = 1'b1;
                  tail_in = 1'b0;
                  if (status.wl_zero) begin
                     cmd.word_clear = 1'b1;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in = ST_READ;
                  end
               end else if (is_space) begin
                  cmd.place    = 1'b1;
                  cmd.is_space = 1'b1;
                  cmd.idx_clear = 1'b1;
                  tail_in    = 1'b1;
                  tail_nl_in = 1'b0;
                  if (status.brk_needed) begin
                     state_in = ST_BRK;
                  end else if (status.wl_zero) begin
                     state_in = ST_TAIL;
                  end else begin
                     state_in = ST_READ;
                  end
               end else if (is_nl) begin
                  cmd.place      = !status.wl_zero;
                  cmd.line_clear = 1'b1;
                  cmd.idx_clear  = 1'b1;
                  tail_in    = 1'b1;
                  tail_nl_in = 1'b1;
                  if (status.wl_zero) begin
                     state_in = ST_TAIL;
                  end else if (status.brk_needed) begin
                     state_in = ST_BRK;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         ST_BRK: begin
            // Insert the line break ahead of the word
            if (status.out_free) begin
               cmd.put     = 1'b1;
               cmd.put_sel = SRC_NL;
               state_in = status.wl_zero ? ST_TAIL : ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_PUT;
         end
         ST_PUT: begin
            // Emit one word byte from the store
            if (status.out_free) begin
               cmd.put      = 1'b1;
               cmd.put_sel  = SRC_RAM;
               cmd.put_last = status.idx_last && !tail_ff;
               cmd.idx_adv  = 1'b1;
               if (!status.idx_last) begin
                  state_in = ST_READ;
               end else if (tail_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  cmd.word_clear = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.put        = 1'b1;
               cmd.put_sel    = tail_nl_ff ? SRC_NL : SRC_SP;
               cmd.put_last   = 1'b1;
               cmd.word_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and tail flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tail_ff    <= 1'b0;
         tail_nl_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tail_ff    <= tail_in;
         tail_nl_ff <= tail_nl_in;
      end
   end

   // A run without a trailing byte can only come from a flush
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT && !tail_ff) |-> $past(state_ff) != ST_BRK)
      else $error("break before a flushed word");

   // A tail byte always ends the run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL && cmd.put) |-> (cmd.put_last && cmd.word_clear))
      else $error("tail byte not marked last");

endmodule

// ===== src/gww_dp.sv =====
module gww_dp
   import gww_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [LINE_W-1:0] csr_wdata,
   input  logic [7:0]        req_tdata,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic [LINE_W-1:0]  line_width_ff, line_width_in;
   logic [LINE_W-1:0]  line_len_ff, line_len_in;
   logic [WLEN_W-1:0]  wl_ff, wl_in;
   logic               ovf_ff, ovf_in;
   logic [WORD_AW-1:0] idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               out_trunc_ff, out_trunc_in;

   logic [WLEN_W:0]    fit_len;
   logic [LINE_W:0]    fit_sum;
   logic               fits;
   logic               word_full;
   logic               ram_we;
   logic [7:0]         ram_rdata;

   // Fit check: line length plus word (and its space) against the width
   assign fit_len = cmd.is_space ? ({1'b0, wl_ff} + (WLEN_W+1)'(1)) : {1'b0, wl_ff};
   assign fit_sum = {1'b0, line_len_ff} + (LINE_W+1)'(fit_len);
   assign fits    = fit_sum <= {1'b0, line_width_ff};

   assign word_full = (wl_ff == WLEN_W'(WORD_CAPACITY));
   assign ram_we    = cmd.store && !word_full;

   assign status.wl_zero    = (wl_ff == '0);
   assign status.brk_needed = !fits && (line_len_ff != '0);
   assign status.idx_last   = (WLEN_W'(idx_ff) + WLEN_W'(1)) == wl_ff;
   assign status.out_free   = !out_valid_ff || rsp_tready;

   gww_ram #(
      .WIDTH(8),
      .DEPTH(WORD_CAPACITY)
   ) u_word_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(wl_ff[WORD_AW-1:0]),
      .wdata(req_tdata),
      .re   (cmd.rd_en),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   // Next values of line, word and output state
   always_comb begin
      line_width_in = csr_wen ? csr_wdata : line_width_ff;

      line_len_in = line_len_ff;
      priority if (cmd.line_clear) begin
         line_len_in = '0;
      end else if (cmd.place) begin
         line_len_in = fits ? fit_sum[LINE_W-1:0] : LINE_W'(fit_len);
      end

      wl_in  = wl_ff;
      ovf_in = ovf_ff;
      priority if (cmd.word_clear) begin
         wl_in  = '0;
         ovf_in = 1'b0;
      end else if (cmd.store) begin
         if (word_full) begin
            ovf_in = 1'b1;
         end else begin
            wl_in = wl_ff + WLEN_W'(1);
         end
      end

      idx_in = idx_ff;
      priority if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_adv) begin
         idx_in = idx_ff + WORD_AW'(1);
      end

      // Output register: load on put, drop once taken
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;
      if (cmd.put) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.put_last;
         out_trunc_in = ovf_ff;
         unique case (cmd.put_sel)
            SRC_NL:  out_char_in = NL_BYTE;
            SRC_SP:  out_char_in = SP_BYTE;
            SRC_RAM: out_char_in = ram_rdata;
            default: out_char_in = NL_BYTE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         line_len_ff   <= '0;
         wl_ff         <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         line_width_ff <= line_width_in;
         line_len_ff   <= line_len_in;
         wl_ff         <= wl_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

   // Pending word never outgrows the store
   assert property (@(posedge clock) disable iff (reset)
      wl_ff <= WLEN_W'(WORD_CAPACITY))
      else $error("word length beyond capacity");

   // Overflow only with a full word
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> word_full)
      else $error("overflow flag without a full word");

   // Never overwrite a byte the receiver has not taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten");

endmodule

// ===== src/greedy_word_wrap.sv =====
// Greedy word wrap.
// req channel: one text byte per transaction. req_tdata carries the byte,
// req_tuser set marks a flush (end of text), and the byte is then ignored.
// rsp channel: the wrapped text, one byte per transaction, including the
// inserted line breaks; rsp_tlast marks the final byte caused by one input
// and rsp_tuser flags a run whose word lost bytes to the 62-byte word store.
// csr_wen/csr_wdata write the line width (reset value 75); the user must
// write it only while idle, as the block itself does not enforce this.
// Timing: an ordinary byte is taken and stored and gives no output. A
// space, newline or flush is taken, then the block emits any inserted
// break, then each word byte (word store read, then output register
// load) and then the trailing space or newline, if there is one. Each
// word byte needs its own read through the single word store read port.
// req_tready is low while a run is being emitted. A stalled receiver holds
// the output register and the run waits; the next input is taken while the
// final byte of a run still waits in the output register.
// Reset is synchronous: it empties the line and word and drops any output.
module greedy_word_wrap
   import gww_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [LINE_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] char_code
   input  logic              req_tuser,   // [0] flush
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] char_out
   output logic              rsp_tlast,
   output logic              rsp_tuser    // [0] word_truncated
);

   cmd_type    cmd;
   status_type status;

   gww_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   gww_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== dv/tb_greedy_word_wrap.sv =====
module tb_greedy_word_wrap
   import gww_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_PCT = 11;

   // One wrapped output byte as the block should emit it
   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
      logic       word_truncated;
   } wrap_byte_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wen;
   logic [LINE_W-1:0] csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // [7:0] char_code
   logic              req_tuser;   // [0] flush
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;   // [7:0] char_out
   logic              rsp_tlast;
   logic              rsp_tuser;   // [0] word_truncated

   // Predicted wrap state
   logic [LINE_W-1:0] width_now;
   int unsigned       line_len;
   int unsigned       word_len;
   logic              trunc_seen;
   logic [7:0]        word_store [WORD_CAPACITY];

   wrap_byte_type     wrapped_text_q[$];
   wrap_byte_type     run_bytes[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                sent_count = 0;
   logic              req_idle_on = 1'b1;
   logic              rsp_idle_on = 1'b1;

   greedy_word_wrap u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor ------------------------------------------------------------

   function automatic void emit_byte(logic [7:0] b);
      wrap_byte_type item;
      item.char_out = b;
      item.last = 1'b0;
      item.word_truncated = trunc_seen;
      run_bytes = {run_bytes, item};
   endfunction

   function automatic void emit_word();
      for (int unsigned i = 0; i < word_len; i++) begin
         emit_byte(word_store[i]);
      end
   endfunction

   // Fit the word on the current line, break first when it does not fit on a non-empty line
   function automatic void fit_word(int unsigned len);
      if (line_len + len <= int'(width_now)) begin
         line_len = line_len + len;
      end else begin
         if (line_len != 0) emit_byte(NL_BYTE);
         line_len = len;
      end
      line_len = line_len & 32'hFF;
   endfunction

   function automatic void clear_word();
      word_len = 0;
      trunc_seen = 1'b0;
   endfunction

   function automatic void wrap_predict(logic [7:0] code, logic flush);
      wrap_byte_type item;
      run_bytes.delete();
      if (flush) begin
         emit_word();
         clear_word();
         line_len = 0;
      end else if (code == SP_BYTE) begin
         fit_word(word_len + 1);
         emit_word();
         emit_byte(SP_BYTE);
         clear_word();
      end else if (code == NL_BYTE) begin
         if (word_len != 0) begin
            fit_word(word_len);
            emit_word();
         end
         emit_byte(NL_BYTE);
         clear_word();
         line_len = 0;
      end else if (word_len < WORD_CAPACITY) begin
         word_store[word_len] = code;
         word_len = word_len + 1;
      end else begin
         trunc_seen = 1'b1;
      end
      // Mark the final byte of the run and queue the run
      for (int i = 0; i < run_bytes.size(); i++) begin
         item = run_bytes[i];
         item.last = (i == run_bytes.size() - 1);
         wrapped_text_q = {wrapped_text_q, item};
      end
   endfunction

   // Driver side ----------------------------------------------------------

   // Send one text transaction, predict its output at acceptance
   task automatic send_text_byte(input logic [7:0] code, input logic flush);
      @(negedge clock);
      while (req_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tuser <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      wrap_predict(code, flush);
      sent_count++;
   endtask

   function automatic logic [7:0] word_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == NL_BYTE || b == SP_BYTE);
      return b;
   endfunction

   task automatic send_word(input int len);
      for (int i = 0; i < len; i++) send_text_byte(word_char(), 1'b0);
   endtask

   // Drop valid and wait until every predicted byte has come out
   task automatic drain_text();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (wrapped_text_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_width(input logic [LINE_W-1:0] w);
      drain_text();
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= w;
      @(negedge clock);
      csr_wen <= 1'b0;
      width_now = w;
   endtask

   // Random text: mostly words with space, newline or flush ends, some noise
   task automatic send_random_text(input int n_items, input int max_word);
      int start;
      int pick;
      start = sent_count;
      while (sent_count - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end else begin
            if ($urandom_range(0, 99) < 4) send_word($urandom_range(55, 70));
            else send_word($urandom_range(0, max_word));
            pick = $urandom_range(0, 99);
            if (pick < 70) send_text_byte(SP_BYTE, 1'b0);
            else if (pick < 90) send_text_byte(NL_BYTE, 1'b0);
            else send_text_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Receiver side --------------------------------------------------------

   // Stall the output at random
   always @(negedge clock) begin
      rsp_tready <= !(rsp_idle_on && $urandom_range(0, 99) < IDLE_PCT);
   end

   // Compare each output transaction with the oldest prediction
   always @(posedge clock) begin
      wrap_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (wrapped_text_q.size() == 0) begin
            $display("%0t: unexpected output byte: expected none, actual %h last %b trunc %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            mismatch_count++;
         end else begin
            want = wrapped_text_q.pop_front();
            if (rsp_tdata !== want.char_out) begin
               $display("%0t: char_out: expected %h, actual %h",
                        $time, want.char_out, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last: expected %b, actual %b", $time, want.last, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== want.word_truncated) begin
               $display("%0t: word_truncated: expected %b, actual %b",
                        $time, want.word_truncated, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Tests ----------------------------------------------------------------

   // Reset width: empty-word cases, byte extremes, flush ignoring its byte
   task automatic test_directed();
      send_text_byte(NL_BYTE, 1'b0);          // newline with no word
      send_text_byte(8'hA5, 1'b1);            // flush with no word
      send_text_byte(SP_BYTE, 1'b0);          // space with no word
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b0);
      send_text_byte(SP_BYTE, 1'b0);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h62, 1'b0);
      send_text_byte(NL_BYTE, 1'b0);          // word then newline
      send_text_byte(8'h78, 1'b0);
      send_text_byte(SP_BYTE, 1'b1);          // flush carrying a space byte
      send_text_byte(8'h79, 1'b0);
      send_text_byte(NL_BYTE, 1'b1);          // flush carrying a newline byte
      send_text_byte(8'hFF, 1'b1);
      send_word(40);
      send_text_byte(SP_BYTE, 1'b0);
      send_word(40);                          // does not fit: break first
      send_text_byte(NL_BYTE, 1'b0);
      send_word(3);
      send_text_byte(8'h00, 1'b1);
   endtask

   // Narrowest widths: wide words on an empty line, zero width
   task automatic test_narrow_width();
      set_line_width(8'd1);
      send_word(5);
      send_text_byte(SP_BYTE, 1'b0);
      send_word(1);
      send_text_byte(SP_BYTE, 1'b0);
      send_random_text(20, 4);
      set_line_width(8'd0);
      send_random_text(10, 4);
   endtask

   // Words at and beyond the store capacity, each ending kind
   task automatic test_word_overflow();
      set_line_width(8'd30);
      send_word(WORD_CAPACITY);
      send_text_byte(SP_BYTE, 1'b0);
      send_word(WORD_CAPACITY + 2);
      send_text_byte(NL_BYTE, 1'b0);
      send_word(WORD_CAPACITY + 1);
      send_text_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_wide_width();
      set_line_width(8'd255);
      send_random_text(30, 40);
   endtask

   // Back-to-back traffic, no stalls on either side
   task automatic test_no_idle();
      set_line_width(8'($urandom_range(10, 80)));
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random_text(40, 12);
      drain_text();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_widths();
      for (int i = 0; i < 4; i++) begin
         if (i % 2 == 0) set_line_width(8'($urandom_range(6, 30)));
         else set_line_width(8'($urandom_range(1, 255)));
         send_random_text(10, 12);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      width_now = LINE_WIDTH_RESET;
      line_len = 0;
      clear_word();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_narrow_width();
      test_word_overflow();
      test_wide_width();
      test_no_idle();
      test_random_widths();
      drain_text();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
